// ----- design/cmv_pkg.sv -----
// Package for the CoAP message validator: parser phases, status and register codes,
// and the packed layout of the result word.
// No dependencies; imported by coap_message_validator_core.
package cmv_pkg;

    typedef enum logic [3:0] {
        PH_H0      = 4'd0,
        PH_H1      = 4'd1,
        PH_H2      = 4'd2,
        PH_H3      = 4'd3,
        PH_TOKEN   = 4'd4,
        PH_OPT     = 4'd5,
        PH_DX8     = 4'd6,
        PH_DX16H   = 4'd7,
        PH_DX16L   = 4'd8,
        PH_LX8     = 4'd9,
        PH_LX16H   = 4'd10,
        PH_LX16L   = 4'd11,
        PH_VALUE   = 4'd12,
        PH_MARKER  = 4'd13,
        PH_PAYLOAD = 4'd14,
        PH_ERROR   = 4'd15
    } phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FORMAT    = 2'd1;
    localparam logic [1:0] ST_VERSION   = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    localparam logic REG_OPTION_LIMIT  = 1'b0;
    localparam logic REG_PAYLOAD_LIMIT = 1'b1;

    localparam logic [15:0] LIMIT_RESET    = 16'd1024;
    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [1:0]  COAP_VERSION   = 2'd1;
    localparam logic [3:0]  NIB_EXT8       = 4'd13;
    localparam logic [3:0]  NIB_EXT16      = 4'd14;
    localparam logic [3:0]  NIB_RESERVED   = 4'd15;
    localparam logic [3:0]  MAX_TOKEN_LEN  = 4'd8;
    localparam logic [8:0]  EXT8_BIAS      = 9'd13;
    localparam logic [16:0] EXT16_BIAS     = 17'd269;

    localparam int OUT_DATA_W = 72;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [6:0]  pad;
        logic [15:0] payload_length;
        logic [15:0] payload_offset;
        logic        has_payload;
        logic [3:0]  token_len;
        logic [15:0] message_id;
        logic [7:0]  msg_code;
        logic [1:0]  msg_type;
        logic [1:0]  status;
    } cmv_result_t;

endpackage

// ----- design/coap_message_validator_core.sv -----
// CoAP message validator: byte-wide framing checker with an APB limit port and a
// registered result stream with a skid stage.
// Depends on cmv_pkg.
//
// Channel   | Direction | Word contents
// s_axis    | in        | tdata[7:0] message byte, tlast final byte of the message
// m_axis    | out       | one result word per message, 72-bit tdata
// apb       | in/out    | option and payload size limits
//
// One byte per cycle is taken and parsed while the skid register is empty.
// The result of a message is registered into the output register when it is free
// or drained, else into a skid register that holds one further result, so input
// stalls only when both the output register and the skid register are full.
// Reset is synchronous and clears the parser, both limits (to 1024) and valid flags.
module coap_message_validator_core #(
    parameter int MAX_MESSAGE_BYTES = 65535
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] msg_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] status, [3:2] msg_type, [11:4] msg_code, [27:12] message_id,
    // [31:28] token_len, [32] has_payload, [48:33] payload_offset,
    // [64:49] payload_length, [71:65] zero
    output logic [cmv_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import cmv_pkg::*;

    localparam logic [15:0] MaxBytes = 16'(MAX_MESSAGE_BYTES);

    logic [15:0] opt_limit_reg;
    logic [15:0] pay_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] byte_index_reg, byte_index_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [7:0]  ext_hi_reg, ext_hi_next;
    logic [3:0]  len_nib_reg, len_nib_next;
    logic [16:0] left_reg, left_next;
    logic [15:0] pstart_reg, pstart_next;
    logic [1:0]  err_reg, err_next;

    cmv_result_t out_reg, skid_reg, result_next;
    logic        out_valid_reg, skid_valid_reg;

    logic        in_fire;
    logic        cfg_write;
    logic        fail_req;
    logic [1:0]  fail_code;
    logic        len_stage_req;
    logic        set_len_req;
    logic [16:0] set_len_val;
    logic [15:0] pay_count;
    logic [3:0]  tkl;
    logic [2:0]  code_class;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_OPTION_LIMIT:  prdata = {16'd0, opt_limit_reg};
            REG_PAYLOAD_LIMIT: prdata = {16'd0, pay_limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opt_limit_reg <= LIMIT_RESET;
            pay_limit_reg <= LIMIT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_OPTION_LIMIT) begin
                opt_limit_reg <= pwdata[15:0];
            end else begin
                pay_limit_reg <= pwdata[15:0];
            end
        end
    end

    assign tkl        = hdr_reg[27:24];
    assign code_class = hdr_reg[23:21];

    always_comb begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        hdr_next        = hdr_reg;
        ext_hi_next     = ext_hi_reg;
        len_nib_next    = len_nib_reg;
        left_next       = left_reg;
        pstart_next     = pstart_reg;
        err_next        = err_reg;
        fail_req        = 1'b0;
        fail_code       = ST_FORMAT;
        len_stage_req   = 1'b0;
        set_len_req     = 1'b0;
        set_len_val     = 17'd0;

        if (phase_reg != PH_ERROR) begin
            if (byte_index_reg >= MaxBytes) begin
                fail_req = 1'b1;
            end else begin
                byte_index_next = byte_index_reg + 16'd1;
                unique case (phase_reg)
                    PH_H0: begin
                        hdr_next[31:24] = s_axis_tdata;
                        phase_next      = PH_H1;
                    end
                    PH_H1: begin
                        hdr_next[23:16] = s_axis_tdata;
                        phase_next      = PH_H2;
                    end
                    PH_H2: begin
                        hdr_next[15:8] = s_axis_tdata;
                        phase_next     = PH_H3;
                    end
                    PH_H3: begin
                        hdr_next[7:0] = s_axis_tdata;
                        if (hdr_reg[31:30] != COAP_VERSION) begin
                            fail_req  = 1'b1;
                            fail_code = ST_VERSION;
                        end else if (tkl > MAX_TOKEN_LEN) begin
                            fail_req = 1'b1;
                        end else if (hdr_reg[23:16] == 8'd0 && tkl != 4'd0) begin
                            fail_req = 1'b1;
                        end else if (code_class == 3'd1 || code_class == 3'd6
                                     || code_class == 3'd7) begin
                            fail_req = 1'b1;
                        end else if (tkl != 4'd0) begin
                            left_next  = {13'd0, tkl};
                            phase_next = PH_TOKEN;
                        end else begin
                            phase_next = PH_OPT;
                        end
                    end
                    PH_TOKEN, PH_VALUE: begin
                        left_next = left_reg - 17'd1;
                        if (left_reg == 17'd1) begin
                            phase_next = PH_OPT;
                        end
                    end
                    PH_OPT: begin
                        if (hdr_reg[23:16] == 8'd0) begin
                            fail_req = 1'b1;
                        end else if (s_axis_tdata == PAYLOAD_MARKER) begin
                            pstart_next = byte_index_reg + 16'd1;
                            phase_next  = PH_MARKER;
                        end else begin
                            len_nib_next = s_axis_tdata[3:0];
                            if (s_axis_tdata[7:4] == NIB_RESERVED) begin
                                fail_req = 1'b1;
                            end else if (s_axis_tdata[7:4] == NIB_EXT8) begin
                                phase_next = PH_DX8;
                            end else if (s_axis_tdata[7:4] == NIB_EXT16) begin
                                phase_next = PH_DX16H;
                            end else begin
                                len_stage_req = 1'b1;
                            end
                        end
                    end
                    PH_DX8:   len_stage_req = 1'b1;
                    PH_DX16H: phase_next = PH_DX16L;
                    PH_DX16L: len_stage_req = 1'b1;
                    PH_LX8: begin
                        set_len_req = 1'b1;
                        set_len_val = {8'd0, {1'b0, s_axis_tdata} + EXT8_BIAS};
                    end
                    PH_LX16H: begin
                        ext_hi_next = s_axis_tdata;
                        phase_next  = PH_LX16L;
                    end
                    PH_LX16L: begin
                        set_len_req = 1'b1;
                        set_len_val = {1'b0, ext_hi_reg, s_axis_tdata} + EXT16_BIAS;
                    end
                    PH_MARKER:  phase_next = PH_PAYLOAD;
                    PH_PAYLOAD: phase_next = PH_PAYLOAD;
                    default:    phase_next = phase_reg;
                endcase
            end
        end

        if (len_stage_req) begin
            if (len_nib_next < NIB_EXT8) begin
                set_len_req = 1'b1;
                set_len_val = {13'd0, len_nib_next};
            end else if (len_nib_next == NIB_EXT8) begin
                phase_next = PH_LX8;
            end else if (len_nib_next == NIB_EXT16) begin
                phase_next = PH_LX16H;
            end else begin
                fail_req = 1'b1;
            end
        end

        if (set_len_req) begin
            if (set_len_val > {1'b0, opt_limit_reg}) begin
                fail_req = 1'b1;
            end else if (set_len_val == 17'd0) begin
                phase_next = PH_OPT;
            end else begin
                left_next  = set_len_val;
                phase_next = PH_VALUE;
            end
        end

        if (fail_req) begin
            phase_next = PH_ERROR;
            err_next   = fail_code;
        end
    end

    assign pay_count = byte_index_next - pstart_next;

    always_comb begin
        result_next                = '0;
        result_next.msg_type       = hdr_next[29:28];
        result_next.msg_code       = hdr_next[23:16];
        result_next.message_id     = hdr_next[15:0];
        result_next.token_len      = hdr_next[27:24];
        if (err_next != ST_OK) begin
            result_next.status = err_next;
        end else if (phase_next == PH_OPT) begin
            result_next.status = ST_OK;
        end else if (phase_next == PH_PAYLOAD) begin
            if (pay_count > pay_limit_reg) begin
                result_next.status = ST_TOO_LARGE;
            end else begin
                result_next.status         = ST_OK;
                result_next.has_payload    = 1'b1;
                result_next.payload_offset = pstart_next;
                result_next.payload_length = pay_count;
            end
        end else begin
            result_next.status = ST_FORMAT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && s_axis_tlast)) begin
            phase_reg      <= PH_H0;
            byte_index_reg <= 16'd0;
            hdr_reg        <= 32'd0;
            ext_hi_reg     <= 8'd0;
            len_nib_reg    <= 4'd0;
            left_reg       <= 17'd0;
            pstart_reg     <= 16'd0;
            err_reg        <= ST_OK;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            hdr_reg        <= hdr_next;
            ext_hi_reg     <= ext_hi_next;
            len_nib_reg    <= len_nib_next;
            left_reg       <= left_next;
            pstart_reg     <= pstart_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_axis_tready && skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (in_fire && s_axis_tlast) begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_reg       <= result_next;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= result_next;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register is empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_axis_tlast) |=> (phase_reg == PH_H0 && byte_index_reg == 16'd0))
        else $error("parser not cleared after the final byte of a message");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ERROR) |-> (err_reg != ST_OK))
        else $error("error phase reached without an error code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.has_payload) |-> (out_reg.status == ST_OK))
        else $error("payload reported with a failing status");

endmodule
